// ----- rtl/bsc_pkg.sv -----
// package of the banker's safety check: sizes, codes and controller/datapath structs
package bsc_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 8;
    localparam int VALUE_BITS    = 16;

    localparam int CMD_BITS      = 2;
    localparam int PINDEX_BITS   = 4;
    localparam int RINDEX_BITS   = 3;
    localparam int VALUE_IN_BITS = 16;
    localparam int PID_BITS      = 4;
    localparam int NP_CFG_BITS   = 5;
    localparam int NR_CFG_BITS   = 4;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam int PROC_IDX_BITS = $clog2(MAX_PROCESSES);
    localparam int PROC_CNT_BITS = $clog2(MAX_PROCESSES + 1);
    localparam int RES_IDX_BITS  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int RES_CNT_BITS  = $clog2(MAX_RESOURCES + 1);
    localparam int FREE_BITS     = VALUE_BITS + PROC_IDX_BITS + 1;
    localparam int MEM_DEPTH     = MAX_PROCESSES * MAX_RESOURCES;
    localparam int MEM_ADDR_BITS = $clog2(MEM_DEPTH);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WR_MAX   = 2'd0,
        CMD_WR_ALLOC = 2'd1,
        CMD_WR_TOTAL = 2'd2,
        CMD_RUN      = 2'd3
    } t_command;

    typedef enum logic [0:0] {
        REG_NUM_PROCESSES = 1'b0,
        REG_NUM_RESOURCES = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SUM,
        S_CHK,
        S_CHK_WAIT,
        S_DECIDE,
        S_PASS_END,
        S_UNSAFE
    } t_state;

    typedef struct packed {
        logic                     load;
        logic                     init;
        logic                     sum_rd;
        logic                     chk_rd;
        logic                     fits_set;
        logic                     finish;
        logic                     emit_unsafe;
        logic                     pass_start;
        logic [PROC_IDX_BITS-1:0] proc_idx;
        logic [RES_IDX_BITS-1:0]  res_idx;
        logic [PROC_CNT_BITS-1:0] np;
        logic [RES_CNT_BITS-1:0]  nr;
    } t_cmd;

    typedef struct packed {
        logic done_cur;
        logic fits;
        logic progress;
        logic all_done;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/bankers_safety_check_top.sv -----
// top level of the banker's safety check: apb registers, controller and datapath
// load items: one per cycle while idle, no result
// run item: free units formed from totals less all allocations, then passes that skip done
// processes, check others per resource, wait and decide; a held result slot stalls the walk
// input ready drops at run acceptance, back with the unsafe result or after the final pass end
// reset: synchronous active low, clears control state, registers to 16 and 8; tables undefined
module bankers_safety_check_top
    import bsc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CMD_BITS-1:0]      i_command,
    input  logic [PINDEX_BITS-1:0]   i_process_index,
    input  logic [RINDEX_BITS-1:0]   i_resource_index,
    input  logic [VALUE_IN_BITS-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [PID_BITS-1:0]      o_process_id,
    output logic                     o_unsafe,
    output logic                     o_last
);

    logic [NP_CFG_BITS-1:0] r_num_processes;
    logic [NR_CFG_BITS-1:0] r_num_resources;
    logic                   w_wr;
    t_reg_idx               w_reg;
    t_cmd                   w_cmd;
    t_stat                  w_stat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_processes <= NP_CFG_BITS'(MAX_PROCESSES);
            r_num_resources <= NR_CFG_BITS'(MAX_RESOURCES);
        end else if (w_wr) begin
            unique case (w_reg)
                REG_NUM_PROCESSES: r_num_processes <= pwdata[NP_CFG_BITS-1:0];
                REG_NUM_RESOURCES: r_num_resources <= pwdata[NR_CFG_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_NUM_PROCESSES: prdata = APB_DATA_BITS'(r_num_processes);
            REG_NUM_RESOURCES: prdata = APB_DATA_BITS'(r_num_resources);
            default:           prdata = '0;
        endcase
    end

    bsc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_command (i_command),
        .i_cfg_np  (r_num_processes),
        .i_cfg_nr  (r_num_resources),
        .i_stat    (w_stat),
        .o_in_ready(o_in_ready),
        .o_cmd     (w_cmd)
    );

    bsc_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_command       (i_command),
        .i_process_index (i_process_index),
        .i_resource_index(i_resource_index),
        .i_value         (i_value),
        .i_out_ready     (i_out_ready),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .o_process_id    (o_process_id),
        .o_unsafe        (o_unsafe),
        .o_last          (o_last)
    );

endmodule

// ----- rtl/bsc_ram.sv -----
// generic single-port-write ram with registered read
module bsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bsc_dpath.sv -----
// datapath of the banker's safety check: tables, free units, done flags, result register
module bsc_dpath
    import bsc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [CMD_BITS-1:0]      i_command,
    input  logic [PINDEX_BITS-1:0]   i_process_index,
    input  logic [RINDEX_BITS-1:0]   i_resource_index,
    input  logic [VALUE_IN_BITS-1:0] i_value,
    input  logic                     i_out_ready,
    output t_stat                    o_stat,
    output logic                     o_out_valid,
    output logic [PID_BITS-1:0]      o_process_id,
    output logic                     o_unsafe,
    output logic                     o_last
);

    logic                     w_pi_ok;
    logic                     w_ri_ok;
    logic                     w_we_max;
    logic                     w_we_alloc;
    logic [MEM_ADDR_BITS-1:0] w_waddr;
    logic [MEM_ADDR_BITS-1:0] w_raddr;
    logic [VALUE_BITS-1:0]    w_wdata;
    logic [VALUE_BITS-1:0]    w_max_rd;
    logic [VALUE_BITS-1:0]    w_alloc_rd;
    logic [FREE_BITS-1:0]     w_need;
    logic                     w_need_gt;
    logic [RES_IDX_BITS-1:0]  w_ri;
    logic                     w_out_free;

    logic [VALUE_BITS-1:0]    r_total [MAX_RESOURCES];
    logic [FREE_BITS-1:0]     r_free  [MAX_RESOURCES];
    logic [VALUE_BITS-1:0]    r_buf   [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] r_done;
    logic [PROC_CNT_BITS-1:0] r_finished;
    logic                     r_fits;
    logic                     r_progress;
    logic                     r_sum_d;
    logic                     r_chk_d;
    logic [RES_IDX_BITS-1:0]  r_j_d;
    logic                     r_out_valid;
    logic [PID_BITS-1:0]      r_out_pid;
    logic                     r_out_unsafe;
    logic                     r_out_last;

    // load decode
    assign w_pi_ok    = 32'(i_process_index) < MAX_PROCESSES;
    assign w_ri_ok    = 32'(i_resource_index) < MAX_RESOURCES;
    assign w_ri       = RES_IDX_BITS'(i_resource_index);
    assign w_wdata    = VALUE_BITS'(i_value);
    assign w_waddr    = MEM_ADDR_BITS'(32'(i_process_index) * MAX_RESOURCES
                                       + 32'(i_resource_index));
    assign w_raddr    = MEM_ADDR_BITS'(32'(i_cmd.proc_idx) * MAX_RESOURCES
                                       + 32'(i_cmd.res_idx));
    assign w_we_max   = i_cmd.load && w_pi_ok && w_ri_ok
                        && (t_command'(i_command) == CMD_WR_MAX);
    assign w_we_alloc = i_cmd.load && w_pi_ok && w_ri_ok
                        && (t_command'(i_command) == CMD_WR_ALLOC);

    bsc_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(MEM_DEPTH)
    ) u_max_ram (
        .i_clk  (i_clk),
        .i_we   (w_we_max),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_max_rd)
    );

    bsc_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(MEM_DEPTH)
    ) u_alloc_ram (
        .i_clk  (i_clk),
        .i_we   (w_we_alloc),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_alloc_rd)
    );

    // signed need against signed free units
    assign w_need    = FREE_BITS'(w_max_rd) - FREE_BITS'(w_alloc_rd);
    assign w_need_gt = $signed(w_need) > $signed(r_free[r_j_d]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_ri_ok && (t_command'(i_command) == CMD_WR_TOTAL)) begin
            r_total[w_ri] <= w_wdata;
        end
        if (r_chk_d) begin
            r_buf[r_j_d] <= w_alloc_rd;
        end
        r_j_d <= i_cmd.res_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_RESOURCES; k++) begin
                r_free[k] <= '0;
            end
        end else if (i_cmd.init) begin
            for (int k = 0; k < MAX_RESOURCES; k++) begin
                r_free[k] <= FREE_BITS'(r_total[k]);
            end
        end else if (i_cmd.finish) begin
            for (int k = 0; k < MAX_RESOURCES; k++) begin
                if (RES_CNT_BITS'(k) < i_cmd.nr) begin
                    r_free[k] <= r_free[k] + FREE_BITS'(r_buf[k]);
                end
            end
        end else if (r_sum_d) begin
            r_free[r_j_d] <= r_free[r_j_d] - FREE_BITS'(w_alloc_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= '0;
            r_finished <= '0;
            r_fits     <= 1'b0;
            r_progress <= 1'b0;
            r_sum_d    <= 1'b0;
            r_chk_d    <= 1'b0;
        end else begin
            r_sum_d <= i_cmd.sum_rd;
            r_chk_d <= i_cmd.chk_rd;
            if (i_cmd.init) begin
                r_done     <= '0;
                r_finished <= '0;
                r_progress <= 1'b0;
            end else if (i_cmd.finish) begin
                r_done[i_cmd.proc_idx] <= 1'b1;
                r_finished             <= r_finished + PROC_CNT_BITS'(1);
                r_progress             <= 1'b1;
            end else if (i_cmd.pass_start) begin
                r_progress <= 1'b0;
            end
            if (i_cmd.fits_set) begin
                r_fits <= 1'b1;
            end else if (r_chk_d && w_need_gt) begin
                r_fits <= 1'b0;
            end
        end
    end

    // result register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish || i_cmd.emit_unsafe) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_pid    <= PID_BITS'(i_cmd.proc_idx);
            r_out_unsafe <= 1'b0;
            r_out_last   <= (r_finished + PROC_CNT_BITS'(1)) == i_cmd.np;
        end else if (i_cmd.emit_unsafe) begin
            r_out_pid    <= '0;
            r_out_unsafe <= 1'b1;
            r_out_last   <= 1'b1;
        end
    end

    assign o_stat.done_cur = r_done[i_cmd.proc_idx];
    assign o_stat.fits     = r_fits;
    assign o_stat.progress = r_progress;
    assign o_stat.all_done = r_finished == i_cmd.np;
    assign o_stat.out_free = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_process_id = r_out_pid;
    assign o_unsafe     = r_out_unsafe;
    assign o_last       = r_out_last;

`ifndef ASSERT_OFF
    a_finish_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_done[i_cmd.proc_idx])
        else $error("finish on a process already done");
`endif

endmodule

// ----- rtl/bsc_ctrl.sv -----
// controller of the banker's safety check: run sequencing over sum, check and release
module bsc_ctrl
    import bsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [CMD_BITS-1:0]    i_command,
    input  logic [NP_CFG_BITS-1:0] i_cfg_np,
    input  logic [NR_CFG_BITS-1:0] i_cfg_nr,
    input  t_stat                  i_stat,
    output logic                   o_in_ready,
    output t_cmd                   o_cmd
);

    t_state                   r_state;
    t_state                   n_state;
    logic [PROC_IDX_BITS-1:0] r_i;
    logic [PROC_IDX_BITS-1:0] n_i;
    logic [RES_IDX_BITS-1:0]  r_j;
    logic [RES_IDX_BITS-1:0]  n_j;
    logic [PROC_CNT_BITS-1:0] r_np;
    logic [PROC_CNT_BITS-1:0] n_np;
    logic [RES_CNT_BITS-1:0]  r_nr;
    logic [RES_CNT_BITS-1:0]  n_nr;
    logic [PROC_CNT_BITS-1:0] w_np_clamp;
    logic [RES_CNT_BITS-1:0]  w_nr_clamp;
    logic                     w_i_last;
    logic                     w_j_last;

    // saturate registers into the supported range
    always_comb begin
        if (i_cfg_np == '0) begin
            w_np_clamp = PROC_CNT_BITS'(1);
        end else if (32'(i_cfg_np) > MAX_PROCESSES) begin
            w_np_clamp = PROC_CNT_BITS'(MAX_PROCESSES);
        end else begin
            w_np_clamp = PROC_CNT_BITS'(i_cfg_np);
        end
        if (i_cfg_nr == '0) begin
            w_nr_clamp = RES_CNT_BITS'(1);
        end else if (32'(i_cfg_nr) > MAX_RESOURCES) begin
            w_nr_clamp = RES_CNT_BITS'(MAX_RESOURCES);
        end else begin
            w_nr_clamp = RES_CNT_BITS'(i_cfg_nr);
        end
    end

    assign w_i_last = (PROC_CNT_BITS'(r_i) + PROC_CNT_BITS'(1)) == r_np;
    assign w_j_last = (RES_CNT_BITS'(r_j) + RES_CNT_BITS'(1)) == r_nr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_np    <= PROC_CNT_BITS'(1);
            r_nr    <= RES_CNT_BITS'(1);
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_np    <= n_np;
            r_nr    <= n_nr;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_i            = r_i;
        n_j            = r_j;
        n_np           = r_np;
        n_nr           = r_nr;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.proc_idx = r_i;
        o_cmd.res_idx  = r_j;
        o_cmd.np       = r_np;
        o_cmd.nr       = r_nr;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (t_command'(i_command) == CMD_RUN) begin
                        n_np    = w_np_clamp;
                        n_nr    = w_nr_clamp;
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_INIT;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_rd = 1'b1;
                if (w_j_last) begin
                    n_j = '0;
                    if (w_i_last) begin
                        n_i     = '0;
                        n_state = S_CHK;
                    end else begin
                        n_i = r_i + PROC_IDX_BITS'(1);
                    end
                end else begin
                    n_j = r_j + RES_IDX_BITS'(1);
                end
            end
            S_CHK: begin
                if (i_stat.done_cur) begin
                    if (w_i_last) begin
                        n_state = S_PASS_END;
                    end else begin
                        n_i = r_i + PROC_IDX_BITS'(1);
                    end
                end else begin
                    o_cmd.chk_rd   = 1'b1;
                    o_cmd.fits_set = (r_j == '0);
                    if (w_j_last) begin
                        n_j     = '0;
                        n_state = S_CHK_WAIT;
                    end else begin
                        n_j = r_j + RES_IDX_BITS'(1);
                    end
                end
            end
            S_CHK_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_stat.fits || i_stat.out_free) begin
                    o_cmd.finish = i_stat.fits;
                    if (w_i_last) begin
                        n_state = S_PASS_END;
                    end else begin
                        n_i     = r_i + PROC_IDX_BITS'(1);
                        n_state = S_CHK;
                    end
                end
            end
            S_PASS_END: begin
                if (i_stat.all_done) begin
                    n_state = S_IDLE;
                end else if (!i_stat.progress) begin
                    n_state = S_UNSAFE;
                end else begin
                    o_cmd.pass_start = 1'b1;
                    n_i              = '0;
                    n_state          = S_CHK;
                end
            end
            S_UNSAFE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_unsafe = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_finish_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (i_stat.fits && i_stat.out_free))
        else $error("finish without fit or free result slot");

    a_unsafe_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_unsafe |=> o_in_ready)
        else $error("unsafe result did not end the run");

    a_run_starts_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && (t_command'(i_command) == CMD_RUN)) |=> o_cmd.init)
        else $error("run item not followed by init");
`endif

endmodule
